// ===== design/cpsc_pkg.sv =====
// shared types and constants for the caseless pad-space string compare
`default_nettype none

package cpsc_pkg;

  // byte and difference widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned DiffW = 9;

  // character codes used by the fold
  localparam logic [ByteW-1:0] PadByte    = 8'h20;
  localparam logic [ByteW-1:0] LowerFirst = 8'h61;
  localparam logic [ByteW-1:0] LowerLast  = 8'h7A;
  localparam logic [ByteW-1:0] CaseShift  = 8'h20;

  typedef logic [ByteW-1:0]        byte_t;
  typedef logic signed [DiffW-1:0] diff_t;

  // one position handed from the input stage to the decision logic
  typedef struct packed {
    logic  valid;
    logic  last;
    diff_t diff;
  } step_t;

  // fold one side: pad with space when absent, lowercase to uppercase
  function automatic byte_t fold_byte(input logic has, input byte_t value);
    byte_t c;
    c = value;
    if (!has) begin
      c = PadByte;
    end else if (value >= LowerFirst && value <= LowerLast) begin
      c = value - CaseShift;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/cpsc_if.sv =====
// valid/ready channel interfaces for position beats and result beats
`default_nettype none

interface cpsc_in_if;
  logic             valid;
  logic             ready;
  cpsc_pkg::byte_t  byte_a;
  logic             has_a;
  cpsc_pkg::byte_t  byte_b;
  logic             has_b;
  logic             last_pos;

  modport source (output valid, byte_a, has_a, byte_b, has_b, last_pos, input ready);
  modport sink   (input valid, byte_a, has_a, byte_b, has_b, last_pos, output ready);
endinterface

interface cpsc_out_if;
  logic            valid;
  logic            ready;
  cpsc_pkg::diff_t difference;

  modport source (output valid, difference, input ready);
  modport sink   (input valid, difference, output ready);
endinterface

`default_nettype wire

// ===== design/caseless_pad_space_compare.sv =====
// top level of the caseless pad-space string compare
// Takes one position of two strings per beat (a byte and a present flag for
// each side, plus a last-position mark) and returns one signed 9-bit result
// beat for each comparison: the first nonzero difference of the uppercase
// folded bytes, a minus b, with an absent byte read as a space, or zero when
// the strings match. A position beat is accepted every cycle, and input flow
// stops only while a last position waits on a full result register that the
// sink is not draining. Each beat is held in the input register, where the
// fold, subtract and latch act on it, and the result of a last position is
// then taken into the output register.
`default_nettype none

module caseless_pad_space_compare (
  input wire logic   clk,
  input wire logic   rst,
  cpsc_in_if.sink    item,
  cpsc_out_if.source result
);

  logic            stage_valid;
  cpsc_pkg::byte_t stage_byte_a;
  logic            stage_has_a;
  cpsc_pkg::byte_t stage_byte_b;
  logic            stage_has_b;
  logic            stage_last;
  logic            advance;
  logic            result_free;
  logic            decided;
  cpsc_pkg::diff_t diff;
  cpsc_pkg::step_t step;

  // stage moves on unless a last position is blocked by the result register
  assign advance    = stage_valid && (!stage_last || result_free);
  assign item.ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      stage_byte_a <= item.byte_a;
      stage_has_a  <= item.has_a;
      stage_byte_b <= item.byte_b;
      stage_has_b  <= item.has_b;
      stage_last   <= item.last_pos;
    end
  end

  cpsc_fold_diff u_fold_diff (
    .byte_a (stage_byte_a),
    .has_a  (stage_has_a),
    .byte_b (stage_byte_b),
    .has_b  (stage_has_b),
    .diff   (diff)
  );

  // position handed to the decision logic
  assign step.valid = advance;
  assign step.last  = stage_last;
  assign step.diff  = diff;

  cpsc_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .result_diff  (result.difference),
    .result_free  (result_free),
    .decided      (decided)
  );

  // a stalled stage keeps its beat
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("input stage dropped a stalled beat");

  // a last position that advances always produces a result beat
  assert property (@(posedge clk) disable iff (rst)
    advance && stage_last |=> result.valid)
    else $error("last position gave no result beat");

  // the decision only sets on a position that moved and was not last
  assert property (@(posedge clk) disable iff (rst)
    $rose(decided) |-> $past(advance) && !$past(stage_last))
    else $error("decision set without an advancing position");

  // a waiting result is never overwritten by a new one
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !(advance && stage_last))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== design/cpsc_fold_diff.sv =====
// folds both bytes of one position and forms the signed difference
`default_nettype none

module cpsc_fold_diff (
  input  wire cpsc_pkg::byte_t byte_a,
  input  wire logic            has_a,
  input  wire cpsc_pkg::byte_t byte_b,
  input  wire logic            has_b,
  output cpsc_pkg::diff_t      diff
);

  cpsc_pkg::byte_t fa;
  cpsc_pkg::byte_t fb;

  // case fold with space padding
  assign fa = cpsc_pkg::fold_byte(has_a, byte_a);
  assign fb = cpsc_pkg::fold_byte(has_b, byte_b);

  // zero-extended subtract, range -255..255 fits in 9 bits
  assign diff = cpsc_pkg::diff_t'({1'b0, fa}) - cpsc_pkg::diff_t'({1'b0, fb});

endmodule

`default_nettype wire

// ===== design/cpsc_decide.sv =====
// latches the first nonzero difference and holds the result register
`default_nettype none

module cpsc_decide (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cpsc_pkg::step_t step,
  input  wire logic            result_ready,
  output logic                 result_valid,
  output cpsc_pkg::diff_t      result_diff,
  output logic                 result_free,
  output logic                 decided
);

  cpsc_pkg::diff_t held_difference;
  cpsc_pkg::diff_t held_next;
  logic            take_new;

  // first nonzero difference wins
  assign take_new  = !decided && (step.diff != '0);
  assign held_next = take_new ? step.diff : held_difference;

  // result register can take a beat when empty or draining
  assign result_free = !result_valid || result_ready;

  // comparison state, cleared after the last position
  always_ff @(posedge clk) begin
    if (rst) begin
      decided         <= 1'b0;
      held_difference <= '0;
    end else if (step.valid) begin
      if (step.last) begin
        decided         <= 1'b0;
        held_difference <= '0;
      end else begin
        decided         <= decided || take_new;
        held_difference <= held_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.valid && step.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.last) begin
      result_diff <= held_next;
    end
  end

endmodule

`default_nettype wire
